[design/loop_chunk_dispatcher_top_defines.svh]
// assertion macros for the loop chunk dispatcher
`ifndef LOOP_CHUNK_DISPATCHER_TOP_DEFINES_SVH
`define LOOP_CHUNK_DISPATCHER_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define LCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define LCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[design/lcd_pkg.sv]
// shared constants and types for the loop chunk dispatcher
package lcd_pkg;
  localparam int MaxThreads = 64;
  localparam int IndexWidth = 32;
  localparam int CfgWidth   = 32;
  localparam int CfgIdxW    = 2;
  localparam int OutWidth   = 32;
  localparam int TcWidth    = 7;

  localparam logic [CfgIdxW-1:0] RegMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegChunks  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegThreads = 2'd2;

  localparam logic [1:0] ModeBlocked = 2'd0;
  localparam logic [1:0] ModeCyclic  = 2'd1;
  localparam logic [1:0] ModeGuided  = 2'd2;
  localparam logic [1:0] ModeDynamic = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch request and registers
    logic div_start;  // launch divide of dividend by thread count
    logic div_step;   // one quotient bit
    logic finish;     // compute result, update state
    logic out_load;   // load output register
  } lcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;   // request needs the divider
    logic div_done;
    logic use_mem;    // cyclic request: needs cursor read state
  } lcd_sts_t;
endpackage

[design/lcd_ram.sv]
// generic single port ram with registered read
module lcd_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[design/lcd_ctrl.sv]
// request sequencer for the loop chunk dispatcher
module lcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  lcd_pkg::lcd_sts_t sts,
  output lcd_pkg::lcd_cmd_t cmd
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDec  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StMem  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0] state, state_next;
  logic       rsp_full, rsp_full_next;

  assign req_ready = (state == StIdle);
  assign rsp_valid = rsp_full;

  always_comb begin
    cmd = '0;
    state_next = state;
    rsp_full_next = rsp_full;
    if (rsp_full && rsp_ready) rsp_full_next = 1'b0;
    case (state)
      StIdle: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next = StDec;
        end
      end
      StDec: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next = StDiv;
        end else if (sts.use_mem) begin
          state_next = StMem;
        end else begin
          state_next = StFin;
        end
      end
      StDiv: begin
        if (sts.div_done) state_next = StFin;
        else cmd.div_step = 1'b1;
      end
      StMem: state_next = StFin;
      StFin: begin
        if (!rsp_full || rsp_ready) begin
          cmd.finish = 1'b1;
          cmd.out_load = 1'b1;
          rsp_full_next = 1'b1;
          state_next = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      rsp_full <= 1'b0;
    end else begin
      state <= state_next;
      rsp_full <= rsp_full_next;
    end
  end
endmodule

[design/lcd_dp.sv]
// datapath: registers, cursors, radix-2 divider and result forming
module lcd_dp #(
  parameter int IndexWidth = lcd_pkg::IndexWidth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lcd_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [lcd_pkg::CfgWidth-1:0]   cfg_data,
  input  logic                           req_type,
  input  logic [5:0]                     thread_id,
  input  lcd_pkg::lcd_cmd_t              cmd,
  output lcd_pkg::lcd_sts_t              sts,
  output logic                           has_work,
  output logic [lcd_pkg::OutWidth-1:0]   first_chunk,
  output logic [lcd_pkg::OutWidth-1:0]   last_chunk,
  output logic                           is_last_chunk
);
  localparam int MaxThreads = lcd_pkg::MaxThreads;
  localparam int TidW = $clog2(MaxThreads);
  localparam int W = IndexWidth;
  localparam int CntW = $clog2(W + 1);
  localparam int OW = lcd_pkg::OutWidth;
  localparam int TW = lcd_pkg::TcWidth;
  localparam int XW = (W > OW) ? OW : W;

  logic [1:0]      sched_mode;
  logic [W-1:0]    chunk_count;
  logic [TW-1:0]   thread_count;
  logic [W-1:0]    shared_next;
  logic [MaxThreads-1:0] thread_seen;

  // latched request
  logic            r_start, r_bad, r_fresh;
  logic [5:0]      r_tid;
  logic [1:0]      r_mode;
  logic [W-1:0]    r_n;
  logic [TW+1:0]   r_t;   // effective thread count

  // divider
  logic [W-1:0]    dq, drem;
  logic [CntW-1:0] dcnt;

  logic [W-1:0]    cur_rd, cur_wd;
  logic            cur_we;

  // effective thread count, clamped to 1..MaxThreads
  logic [TW+1:0] t_eff;
  always_comb begin
    t_eff = {2'b0, thread_count};
    if (thread_count == '0) t_eff = (TW+2)'(1);
    else if ({2'b0, thread_count} > (TW+2)'(MaxThreads)) t_eff = (TW+2)'(MaxThreads);
  end

  logic [W-1:0] tid_w, t_w;
  assign tid_w = W'(r_tid);
  assign t_w   = W'(r_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode <= lcd_pkg::ModeBlocked;
      chunk_count <= '0;
      thread_count <= TW'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        lcd_pkg::RegMode:    sched_mode <= cfg_data[1:0];
        lcd_pkg::RegChunks:  chunk_count <= W'(cfg_data);
        lcd_pkg::RegThreads: thread_count <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_start <= ~req_type;
      r_tid <= thread_id;
      r_n <= chunk_count;
      r_t <= t_eff;
      r_bad <= ((TW+2)'(thread_id) >= t_eff);
      r_mode <= (t_eff == (TW+2)'(1)) ? lcd_pkg::ModeBlocked : sched_mode;
      r_fresh <= ~thread_seen[thread_id[TidW-1:0]];
    end
  end

  // guided dividend is remaining count; blocked is n
  logic [W-1:0] dividend;
  logic shared_ok;
  assign shared_ok = shared_next < r_n;
  assign dividend = (r_mode == lcd_pkg::ModeGuided) ? (r_n - shared_next) : r_n;

  always_comb begin
    sts.need_div = ~r_start & ~r_bad &
                   ((r_mode == lcd_pkg::ModeBlocked && r_fresh) ||
                    (r_mode == lcd_pkg::ModeGuided && shared_ok));
    sts.use_mem = ~r_start & ~r_bad & (r_mode == lcd_pkg::ModeCyclic);
    sts.div_done = (dcnt == '0);
  end

  // restoring divider, one quotient bit per cycle
  logic [W:0] trial;
  assign trial = {drem, dq[W-1]} - {1'b0, t_w};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq <= dividend;
      drem <= '0;
      dcnt <= CntW'(W);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - 1'b1;
      if (!trial[W]) begin
        drem <= trial[W-1:0];
        dq <= {dq[W-2:0], 1'b1};
      end else begin
        drem <= {drem[W-2:0], dq[W-1]};
        dq <= {dq[W-2:0], 1'b0};
      end
    end
  end

  lcd_ram #(.Width(W), .Depth(MaxThreads)) u_cursor (
    .clk(clk), .we(cur_we), .addr(r_tid[TidW-1:0]), .wdata(cur_wd), .rdata(cur_rd)
  );

  // result forming
  logic          w_work, w_fin;
  logic [W-1:0]  w_first, w_last, c_val, share, delta, base, blk;
  logic [W:0]    c_sum;
  always_comb begin
    w_work = 1'b0; w_fin = 1'b0; w_first = '0; w_last = '0;
    cur_we = 1'b0; cur_wd = '0;
    c_val = r_fresh ? tid_w : cur_rd;
    c_sum = {1'b0, c_val} + {1'b0, t_w};
    share = dq + W'(drem != '0);
    delta = (share >> 1) + W'(share[0]);
    base = '0; blk = '0;
    if (!r_start && !r_bad) begin
      case (r_mode)
        lcd_pkg::ModeBlocked: begin
          if (r_fresh && r_n != '0 && tid_w < r_n) begin
            w_work = 1'b1;
            if (tid_w < drem) begin
              base = W'(tid_w * (dq + 1'b1));
              blk = dq + 1'b1;
            end else begin
              base = W'(tid_w * dq) + drem;
              blk = dq;
            end
            w_first = base;
            w_last = base + blk - 1'b1;
            w_fin = (r_n < t_w) ? (tid_w == r_n - 1'b1) : (tid_w == t_w - 1'b1);
          end
        end
        lcd_pkg::ModeCyclic: begin
          cur_we = cmd.finish;
          cur_wd = c_val;
          if (c_val < r_n) begin
            w_work = 1'b1;
            w_first = c_val; w_last = c_val;
            w_fin = (c_val == r_n - 1'b1);
            cur_wd = c_sum[W] ? '1 : c_sum[W-1:0];
          end
        end
        lcd_pkg::ModeGuided: begin
          if (shared_ok) begin
            w_work = 1'b1;
            w_first = shared_next;
            w_last = shared_next + delta - 1'b1;
            w_fin = (w_last == r_n - 1'b1);
          end
        end
        default: begin
          if (shared_ok) begin
            w_work = 1'b1;
            w_first = shared_next; w_last = shared_next;
            w_fin = (shared_next == r_n - 1'b1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shared_next <= '0;
      thread_seen <= '0;
    end else if (cmd.finish) begin
      if (r_start) begin
        shared_next <= '0;
        thread_seen <= '0;
      end else if (!r_bad) begin
        thread_seen[r_tid[TidW-1:0]] <= 1'b1;
        if (w_work && r_mode == lcd_pkg::ModeGuided) shared_next <= shared_next + delta;
        if (w_work && r_mode == lcd_pkg::ModeDynamic) shared_next <= shared_next + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      has_work <= w_work;
      first_chunk <= OW'(w_first[XW-1:0]);
      last_chunk <= OW'(w_last[XW-1:0]);
      is_last_chunk <= w_work & w_fin;
    end
  end
endmodule

[design/loop_chunk_dispatcher_top.sv]
// top level of the loop chunk dispatcher
// Hands out loop chunk ranges to a team of threads. A start request (req_type 0) clears the
// shared cursor and the per-thread fresh marks and answers with no work; a next request
// (req_type 1) answers one range per sched_mode: static blocked, static cyclic, guided or
// dynamic. One item at a time: each request passes the idle state (capture), a decode state
// and a finish state; static cyclic adds a state of its own for the cursor ram read, and a
// request that needs the radix-2 divider by the thread count (static blocked on a fresh
// thread, guided with chunks left) adds the divide state. Results sit in an output
// register so a new request can be taken while the last transfer is still pending; a
// second result waits in the finish state until the output register frees up. Configure
// only while idle.
module loop_chunk_dispatcher_top #(
  parameter int IndexWidth = lcd_pkg::IndexWidth
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration writes
  input  logic                         cfg_we,
  input  logic [lcd_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [lcd_pkg::CfgWidth-1:0] cfg_data,
  // request channel
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic                         req_type,
  input  logic [5:0]                   thread_id,
  // result channel
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic                         has_work,
  output logic [lcd_pkg::OutWidth-1:0] first_chunk,
  output logic [lcd_pkg::OutWidth-1:0] last_chunk,
  output logic                         is_last_chunk
);
  lcd_pkg::lcd_cmd_t cmd;
  lcd_pkg::lcd_sts_t sts;

  // sequencer
  lcd_ctrl u_ctrl (
    .clk, .rst, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
  );

  // state, divider and result register
  lcd_dp #(.IndexWidth(IndexWidth)) u_dp (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .req_type, .thread_id, .cmd, .sts,
    .has_work, .first_chunk, .last_chunk, .is_last_chunk
  );
endmodule

[design/lcd_checker.sv]
// port level checks for the loop chunk dispatcher
`include "loop_chunk_dispatcher_top_defines.svh"
module lcd_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic has_work,
  input logic [31:0] first_chunk,
  input logic [31:0] last_chunk,
  input logic is_last_chunk
);
  `LCD_ASSERT_IMP(a_nowork_zero, rsp_valid && !has_work, first_chunk == '0 && last_chunk == '0 && !is_last_chunk, "no-work result not cleared")
  `LCD_ASSERT_IMP(a_range_order, rsp_valid && has_work, first_chunk <= last_chunk, "range reversed")
  `LCD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accepted while busy")
  `LCD_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(first_chunk), "result dropped")
endmodule

bind loop_chunk_dispatcher_top lcd_checker u_lcd_checker (
  .clk, .rst, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
  .has_work, .first_chunk, .last_chunk, .is_last_chunk
);

[sim/tb_loop_chunk_dispatcher_top.sv]
// testbench for the loop chunk dispatcher: directed table, random traffic, scoreboard
module tb_loop_chunk_dispatcher_top;
  localparam int WatchdogLimit = 20000;
  localparam int NumRandom     = 1500;
  localparam int DrainCycles   = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [lcd_pkg::CfgIdxW-1:0] cfg_idx = lcd_pkg::RegMode;
  logic [lcd_pkg::CfgWidth-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  logic req_type = 1'b0;
  logic [5:0] thread_id = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic has_work;
  logic [lcd_pkg::OutWidth-1:0] first_chunk;
  logic [lcd_pkg::OutWidth-1:0] last_chunk;
  logic is_last_chunk;

  loop_chunk_dispatcher_top dut (.*);

  // high and low phases, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic        work;
    logic [31:0] first;
    logic [31:0] last;
    logic        fin;
  } grant_t;

  // one row of the directed table; chk set means the typed-in grant is the expected one
  typedef struct packed {
    logic        wr;     // config write row instead of a request
    logic [1:0]  ridx;
    logic [31:0] rval;
    logic        rtype;
    logic [5:0]  tid;
    logic        chk;
    grant_t      g;
  } row_t;

  // predictor state, mirrored registers
  logic [1:0]  p_mode;
  logic [31:0] p_chunks;
  logic [6:0]  p_threads;
  logic [31:0] p_shared;
  logic [63:0] p_seen;
  logic [31:0] p_cursor [64];

  grant_t grants_due[$];
  int  errors = 0;
  int  idle_cycles = 0;
  logic hold_rsp = 1'b0;

  function automatic grant_t no_grant();
    grant_t g;
    g = '0;
    return g;
  endfunction

  task automatic mirror_write(input logic [1:0] idx, input logic [31:0] val);
    case (idx)
      lcd_pkg::RegMode:    p_mode = val[1:0];
      lcd_pkg::RegChunks:  p_chunks = val;
      lcd_pkg::RegThreads: p_threads = val[6:0];
      default: ;
    endcase
  endtask

  // works out the grant for one request and updates the mirrored state
  function automatic grant_t predict_grant(input logic rtype, input logic [5:0] me);
    grant_t g;
    logic [63:0] t, n, whole, left, base, rem, share, delta, c;
    logic [1:0] mode;
    logic fresh;
    g = no_grant();
    t = 64'(p_threads);
    n = 64'(p_chunks);
    mode = p_mode;
    if (!rtype) begin
      p_shared = '0;
      p_seen = '0;
      return g;
    end
    if (t == 0) t = 1;
    if (t > 64) t = 64;
    if (64'(me) >= t) return g;
    if (t == 1) mode = lcd_pkg::ModeBlocked;
    fresh = !p_seen[me];
    if (fresh) begin
      p_seen[me] = 1'b1;
      p_cursor[me] = 32'(me);
    end
    case (mode)
      lcd_pkg::ModeBlocked: begin
        if (!fresh || n == 0 || 64'(me) >= n) return g;
        whole = n / t;
        left = n % t;
        if (64'(me) < left) begin
          base = 64'(me) * (whole + 1);
          g.last = 32'(base + whole);
        end else begin
          base = 64'(me) * whole + left;
          g.last = 32'(base + whole - 1);
        end
        g.work = 1'b1;
        g.first = 32'(base);
        g.fin = (n < t) ? (64'(me) == n - 1) : (64'(me) == t - 1);
      end
      lcd_pkg::ModeCyclic: begin
        c = 64'(p_cursor[me]);
        if (c >= n) return g;
        // saturate at all ones, which never gets below the chunk count
        p_cursor[me] = (c > 64'hFFFF_FFFF - t) ? 32'hFFFF_FFFF : 32'(c + t);
        g = '{1'b1, c[31:0], c[31:0], c == n - 1};
      end
      default: begin
        if (64'(p_shared) >= n) return g;
        c = 64'(p_shared);
        if (mode == lcd_pkg::ModeGuided) begin
          rem = n - c;
          share = rem / t + 64'((rem % t) != 0);
          delta = share / 2 + 64'(share[0]);
        end else begin
          delta = 1;
        end
        p_shared = 32'(c + delta);
        g = '{1'b1, c[31:0], 32'(c + delta - 1), (c + delta - 1) == n - 1};
      end
    endcase
    return g;
  endfunction

  // random gap: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic wait_drained();
    while (grants_due.size() != 0) @(posedge clk);
    // requests always answer, but let the block settle before touching registers
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_write(idx, val);
  endtask

  // one request transfer; valid stays up across back-to-back items
  task automatic send_request(input logic rtype, input logic [5:0] tid,
                              input logic chk, input grant_t g_typed);
    grant_t g;
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= rtype;
    thread_id <= tid;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    g = predict_grant(rtype, tid);
    // typed-in rows are checked against the typed grant, the rest against the predictor
    grants_due.push_back(chk ? g_typed : g);
  endtask

  task automatic end_requests();
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random request that is mostly well formed: valid thread ids, occasional start
  task automatic random_request(input int tmax);
    logic [5:0] tid;
    if ($urandom_range(99) < 90) tid = 6'($urandom_range(tmax - 1));
    else tid = 6'($urandom_range(63));
    send_request($urandom_range(99) < 6 ? 1'b0 : 1'b1, tid, 1'b0, no_grant());
  endtask

  // result side: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_rsp) begin
      rsp_ready <= 1'b0;
    end else begin
      stall = gap_len();
      rsp_ready <= (stall == 0) || ($urandom_range(3) == 0);
    end
  end

  // scoreboard: each result against the oldest expected grant
  always @(posedge clk) begin
    grant_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (grants_due.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = grants_due.pop_front();
        if (has_work !== e.work) begin
          $error("has_work exp %0d got %0d", e.work, has_work); errors++;
        end
        if (first_chunk !== e.first) begin
          $error("first_chunk exp %0d got %0d", e.first, first_chunk); errors++;
        end
        if (last_chunk !== e.last) begin
          $error("last_chunk exp %0d got %0d", e.last, last_chunk); errors++;
        end
        if (is_last_chunk !== e.fin) begin
          $error("is_last_chunk exp %0d got %0d", e.fin, is_last_chunk); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // directed table: config rows and requests, grants typed in where obvious
  row_t dir_rows[$];
  function automatic row_t cw(input logic [1:0] i, input logic [31:0] v);
    row_t r;
    r = '0; r.wr = 1'b1; r.ridx = i; r.rval = v;
    return r;
  endfunction
  function automatic row_t rq(input logic ty, input logic [5:0] id, input logic chk,
                              input grant_t g);
    row_t r;
    r = '0; r.rtype = ty; r.tid = id; r.chk = chk; r.g = g;
    return r;
  endfunction

  initial begin
    int k, tmax;
    logic [1:0] mode;
    logic [31:0] n;
    for (k = 0; k < 64; k++) p_cursor[k] = '0;
    p_mode = lcd_pkg::ModeBlocked; p_chunks = '0; p_threads = 7'd1;
    p_shared = '0; p_seen = '0;

    // after reset: zero chunks, one thread
    dir_rows.push_back(rq(1'b1, 6'd0, 1'b1, no_grant()));
    dir_rows.push_back(rq(1'b0, 6'd63, 1'b1, no_grant()));   // start answers no work
    dir_rows.push_back(cw(lcd_pkg::RegChunks, 32'hFFFF_FFFF));
    dir_rows.push_back(rq(1'b1, 6'd0, 1'b1, '{1'b1, 32'd0, 32'hFFFF_FFFE, 1'b1}));
    dir_rows.push_back(rq(1'b1, 6'd0, 1'b1, no_grant()));    // repeat blocked request
    dir_rows.push_back(rq(1'b1, 6'd1, 1'b1, no_grant()));    // thread id out of team
    dir_rows.push_back(cw(lcd_pkg::RegThreads, 32'd0));       // zero threads acts as one
    dir_rows.push_back(rq(1'b0, 6'd0, 1'b1, no_grant()));
    dir_rows.push_back(rq(1'b1, 6'd0, 1'b0, no_grant()));
    dir_rows.push_back(cw(lcd_pkg::RegThreads, 32'd127));     // above max acts as 64
    dir_rows.push_back(cw(lcd_pkg::RegMode, {30'd0, lcd_pkg::ModeCyclic}));
    dir_rows.push_back(rq(1'b1, 6'd63, 1'b0, no_grant()));
    dir_rows.push_back(rq(1'b1, 6'd63, 1'b0, no_grant()));
    dir_rows.push_back(cw(lcd_pkg::RegMode, {30'd0, lcd_pkg::ModeGuided}));
    dir_rows.push_back(rq(1'b1, 6'd5, 1'b0, no_grant()));
    dir_rows.push_back(rq(1'b1, 6'd42, 1'b0, no_grant()));
    dir_rows.push_back(cw(lcd_pkg::RegChunks, 32'd1));        // shared cursor past the end
    dir_rows.push_back(rq(1'b1, 6'd5, 1'b1, no_grant()));
    dir_rows.push_back(cw(lcd_pkg::RegMode, {30'd0, lcd_pkg::ModeDynamic}));
    dir_rows.push_back(rq(1'b0, 6'd0, 1'b1, no_grant()));
    dir_rows.push_back(rq(1'b1, 6'd21, 1'b1, '{1'b1, 32'd0, 32'd0, 1'b1}));
    dir_rows.push_back(rq(1'b1, 6'd21, 1'b1, no_grant()));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        end_requests();
        wait_drained();
        write_reg(dir_rows[i].ridx, dir_rows[i].rval);
      end else begin
        send_request(dir_rows[i].rtype, dir_rows[i].tid, dir_rows[i].chk, dir_rows[i].g);
      end
    end
    end_requests();
    wait_drained();

    // cyclic requests against a chunk count near the top of the index range
    write_reg(lcd_pkg::RegChunks, 32'hFFFF_FFFE);
    write_reg(lcd_pkg::RegThreads, 32'd64);
    write_reg(lcd_pkg::RegMode, {30'd0, lcd_pkg::ModeCyclic});
    send_request(1'b0, 6'd0, 1'b0, no_grant());
    for (k = 0; k < 8; k++) send_request(1'b1, 6'd62, 1'b0, no_grant());
    end_requests();

    // long receiver hold-off while the sender keeps offering
    hold_rsp <= 1'b1;
    fork
      begin
        for (k = 0; k < 6; k++) send_request(1'b1, k[5:0], 1'b0, no_grant());
        end_requests();
      end
      begin
        repeat (300) @(posedge clk);
        hold_rsp <= 1'b0;
      end
    join
    wait_drained();

    // random phases, each with a fresh register setting
    k = 0;
    while (k < NumRandom) begin
      mode = 2'($urandom_range(3));
      case ($urandom_range(5))
        0: n = 32'd0;
        1: n = $urandom;
        2: n = 32'hFFFF_FFFF - $urandom_range(3);
        default: n = $urandom_range(200);
      endcase
      case ($urandom_range(5))
        0: tmax = 1;
        1: tmax = 64;
        2: tmax = $urandom_range(127, 65);
        default: tmax = $urandom_range(12, 2);
      endcase
      write_reg(lcd_pkg::RegMode, {30'd0, mode});
      write_reg(lcd_pkg::RegChunks, n);
      write_reg(lcd_pkg::RegThreads, 32'(tmax));
      if (tmax > 64) tmax = 64;
      send_request(1'b0, 6'($urandom_range(63)), 1'b0, no_grant());
      repeat ($urandom_range(80, 20)) begin
        random_request(tmax);
        k++;
      end
      end_requests();
      // sender pauses until everything is back
      wait_drained();
    end

    wait_drained();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

[sim.f]
+incdir+design
design/lcd_pkg.sv
design/lcd_ram.sv
design/lcd_ctrl.sv
design/lcd_dp.sv
design/loop_chunk_dispatcher_top.sv
design/lcd_checker.sv
sim/tb_loop_chunk_dispatcher_top.sv
